### rtl/core/egcd_pkg.sv
`timescale 1ns / 1ps

package egcd_pkg;

    // default operand width
    localparam int unsigned DATA_WIDTH_DEF = 32;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } egcd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // take new operands
        logic step;     // one reduction round
        logic capture;  // move the finished value into the result register
    } egcd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;     // one operand has reached zero
    } egcd_sts_t;

endpackage

### rtl/core/egcd_ctrl.sv
`timescale 1ns / 1ps

module egcd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  egcd_pkg::egcd_sts_t sts,
    output egcd_pkg::egcd_cmd_t cmd
);
    import egcd_pkg::*;

    egcd_state_t state_reg;
    egcd_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sts.done && (!out_valid_reg || m_ready)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_RUN: begin
                cmd.step    = !sts.done;
                cmd.capture = sts.done && (!out_valid_reg || m_ready);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result register stays full until its transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

### rtl/core/egcd_dp.sv
`timescale 1ns / 1ps

module egcd_dp #(
    parameter int unsigned DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic [DATA_WIDTH-1:0]   first_value,
    input  logic [DATA_WIDTH-1:0]   second_value,
    input  egcd_pkg::egcd_cmd_t     cmd,
    output egcd_pkg::egcd_sts_t     sts,
    output logic [DATA_WIDTH-1:0]   divisor
);
    import egcd_pkg::*;

    localparam int unsigned KW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [DATA_WIDTH-1:0] res_reg;
    logic [DATA_WIDTH-1:0] diff_ab;
    logic [DATA_WIDTH-1:0] diff_ba;
    logic                  a_ge_b;

    assign a_ge_b  = (a_reg >= b_reg);
    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;

    // load new operands, or one binary gcd round: strip common twos, strip lone twos, or halve the difference
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (cmd.load) begin
            a_next = first_value;
            b_next = second_value;
            k_next = '0;
        end else if (cmd.step) begin
            if (!a_reg[0] && !b_reg[0]) begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end else if (!a_reg[0]) begin
                a_next = a_reg >> 1;
            end else if (!b_reg[0]) begin
                b_next = b_reg >> 1;
            end else if (a_ge_b) begin
                a_next = diff_ab >> 1;
            end else begin
                b_next = diff_ba >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        if (cmd.capture) begin
            res_reg <= (a_reg | b_reg) << k_reg;
        end
    end

    assign sts.done = (a_reg == '0) || (b_reg == '0);
    assign divisor  = res_reg;

endmodule

### rtl/core/euclid_gcd_top.sv
`timescale 1ns / 1ps

// channel   ports                                                 role
// s_        s_valid s_ready s_first_value s_second_value         operand pair in
// m_        m_valid m_ready m_divisor                            greatest common divisor out
//
// one operand pair at a time; an item runs the binary gcd loop in egcd_dp,
// one halving round per cycle until an operand reaches zero
// a zero operand returns the other one, two zeros return zero
// a new pair is taken while the previous result still waits in the output register
// a stalled result holds the loop in its last round until m_ready
// aresetn is synchronous, active low, and clears only the control state

module euclid_gcd_top #(
    parameter int unsigned DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_first_value,
    input  logic [DATA_WIDTH-1:0] s_second_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_divisor
);
    import egcd_pkg::*;

    egcd_cmd_t cmd;
    egcd_sts_t sts;

    // state machine: accept, iterate, hand over to the output register
    egcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // operand registers, twos count and result register
    egcd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .first_value  (s_first_value),
        .second_value (s_second_value),
        .cmd          (cmd),
        .sts          (sts),
        .divisor      (m_divisor)
    );

    // busy right after an input transfer
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // results only leave a finished loop
    a_capture_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> sts.done)
        else $error("result captured before the loop finished");

    // load and round never overlap
    a_load_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.step))
        else $error("load and step in the same cycle");

    // a capture always shows up on the output
    a_capture_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> m_valid)
        else $error("captured result not presented");

endmodule
